FILE: hw/rtl/spm_pkg.sv
package spm_pkg;

	// Stack memory geometry: four byte lanes, one word row per lane address
	localparam int MEM_BYTES = 4096;
	localparam int MEM_AW    = $clog2(MEM_BYTES);
	localparam int ROW_AW    = MEM_AW - 2;
	localparam int NUM_LANES = 4;

	localparam int NUM_REGS  = 16;
	localparam int REG_AW    = 4;
	localparam int LIST_W    = 9;
	localparam int WORD_W    = 32;
	localparam int ADDR_OUT_W = 12;

	localparam logic [REG_AW-1:0] SP_REG = 4'd13;
	localparam logic [REG_AW-1:0] LR_REG = 4'd14;
	localparam logic [REG_AW-1:0] PC_REG = 4'd15;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_PUSH  = 2'd1;
	localparam logic [1:0] MODE_POP   = 2'd2;

	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_STORE = 2'd1;
	localparam logic [1:0] KIND_LOAD  = 2'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic [LIST_W-1:0] reg_list;
		logic [REG_AW-1:0] reg_index;
		logic [WORD_W-1:0] write_value;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic [REG_AW-1:0]     xfer_register;
		logic [ADDR_OUT_W-1:0] mem_address;
		logic [WORD_W-1:0]     xfer_data;
		logic [WORD_W-1:0]     stack_pointer;
		logic                  is_last;
	} res_item_t;

	// One word access to the stack memory at an arbitrary byte address
	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [MEM_AW-1:0] addr;
		logic [WORD_W-1:0] wdata;
	} mem_req_t;

	// Register file write port plus the stack pointer update
	typedef struct packed {
		logic              en;
		logic [REG_AW-1:0] idx;
		logic [WORD_W-1:0] data;
		logic              sp_en;
		logic [WORD_W-1:0] sp_data;
	} rf_wr_t;

endpackage

FILE: hw/rtl/spm_ram.sv
module spm_ram #(
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [1 << AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

FILE: hw/rtl/spm_stack_mem.sv
module spm_stack_mem import spm_pkg::*; (
	input  logic              clk,
	input  mem_req_t          req,
	output logic [WORD_W-1:0] rdata
);

	logic [7:0] bank_rdata [NUM_LANES];
	logic [1:0] lane_q;

	for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
		logic [1:0]        ofs;
		logic [MEM_AW-1:0] baddr;
		logic [7:0]        wbyte;

		// word byte that lands in this lane, and the row it falls on
		assign ofs   = 2'(k) - req.addr[1:0];
		assign baddr = req.addr + MEM_AW'(ofs);
		assign wbyte = 8'(req.wdata >> {ofs, 3'b000});

		spm_ram #(.AW(ROW_AW)) u_ram (
			.clk   (clk),
			.we    (req.wr_en),
			.re    (req.rd_en),
			.addr  (baddr[MEM_AW-1:2]),
			.wdata (wbyte),
			.rdata (bank_rdata[k])
		);
	end

	// hold the lane rotation of the read in flight
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			lane_q <= req.addr[1:0];
		end
	end

	always_comb begin
		for (int j = 0; j < NUM_LANES; j++) begin
			rdata[8*j +: 8] = bank_rdata[lane_q + 2'(j)];
		end
	end

endmodule

FILE: hw/rtl/spm_regfile.sv
module spm_regfile import spm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rf_wr_t            wr,
	input  logic [REG_AW-1:0] rd_idx,
	output logic [WORD_W-1:0] rd_data,
	output logic [WORD_W-1:0] sp
);

	logic [WORD_W-1:0] regs_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else begin
			if (wr.en) begin
				regs_q[wr.idx] <= wr.data;
			end
			if (wr.sp_en) begin
				regs_q[SP_REG] <= wr.sp_data;
			end
		end
	end

	assign rd_data = regs_q[rd_idx];
	assign sp      = regs_q[SP_REG];

endmodule

FILE: hw/rtl/stack_push_pop_multiple_unit.sv
// Thumb-style PUSH/POP engine. A command beat either writes one register of the
// 16-entry register file (r13 is SP), or pushes/pops the registers selected in
// reg_list (r0-r7, plus LR on push or PC on pop) against a byte-addressed stack
// memory, little-endian, with addresses wrapping at the memory size. A write or
// an empty/unused command gives one acknowledge beat; a push or pop gives one
// beat per register moved, in ascending register order, with is_last on the
// final one and the final SP on every beat. Commands are handled one at a time:
// after acceptance a setup state computes SP, then one word moves per cycle
// through the four byte-lane memory port while the result side does not stall.
// After reset the stack memory is cleared one word row per cycle, and no command
// is taken until that pass ends. The result register holds one finished beat;
// while it waits unaccepted the engine holds too, except that setup still moves
// on to a push or pop and a pop may already issue its next load.
module stack_push_pop_multiple_unit import spm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_item_t cmd,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;
	localparam logic [2:0] ST_PUSH  = 3'd3;
	localparam logic [2:0] ST_POP   = 3'd4;

	// Control state
	logic [2:0]        state_q, state_d;
	logic [ROW_AW-1:0] clr_row_q;
	logic              rd_valid_q;
	logic              res_valid_q;

	// Command payload and transfer bookkeeping
	cmd_item_t         item_q;
	logic [LIST_W-1:0] list_q;
	logic [MEM_AW-1:0] addr_q;
	logic [WORD_W-1:0] sp_after_q;
	logic [REG_AW-1:0] rd_reg_q;
	logic [MEM_AW-1:0] rd_addr_q;
	res_item_t         res_q;

	// Datapath
	logic              accept;
	logic              out_free;
	logic              run_item;
	logic [3:0]        cnt;
	logic [WORD_W-1:0] span;
	logic [WORD_W-1:0] sp_new;
	logic [LIST_W-1:0] low_oh;
	logic [LIST_W-1:0] list_rest;
	logic [3:0]        bit_idx;
	logic [REG_AW-1:0] cur_reg;
	logic              push_step, pop_issue, pop_emit;
	logic              emit, emit_last;
	res_item_t         res_d;
	mem_req_t          mem_req;
	logic [WORD_W-1:0] mem_rdata;
	rf_wr_t            rf_wr;
	logic [WORD_W-1:0] rf_rdata;
	logic [WORD_W-1:0] rf_sp;

	spm_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (rf_wr),
		.rd_idx  (cur_reg),
		.rd_data (rf_rdata),
		.sp      (rf_sp)
	);

	spm_stack_mem u_stack_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign out_free  = !res_valid_q || res_ready;

	// Register count and the SP the command leaves behind
	always_comb begin
		cnt = '0;
		for (int i = 0; i < LIST_W; i++) begin
			cnt = cnt + 4'(item_q.reg_list[i]);
		end
		span = {26'd0, cnt, 2'b00};
		sp_new = (item_q.mode == MODE_POP) ? (rf_sp + span) : (rf_sp - span);
		run_item = ((item_q.mode == MODE_PUSH) || (item_q.mode == MODE_POP)) &&
			(item_q.reg_list != '0);
	end

	// Next register in ascending order
	always_comb begin
		low_oh    = list_q & (~list_q + LIST_W'(1));
		list_rest = list_q & ~low_oh;
		bit_idx   = '0;
		for (int i = 0; i < LIST_W; i++) begin
			if (low_oh[i]) begin
				bit_idx = bit_idx | 4'(i);
			end
		end
		if (bit_idx[3]) begin
			cur_reg = (state_q == ST_POP) ? PC_REG : LR_REG;
		end else begin
			cur_reg = bit_idx;
		end
	end

	assign push_step = (state_q == ST_PUSH) && out_free;
	assign pop_emit  = (state_q == ST_POP) && rd_valid_q && out_free;
	assign pop_issue = (state_q == ST_POP) && (list_q != '0) && (!rd_valid_q || out_free);

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		emit_last = 1'b0;
		res_d     = '0;
		mem_req   = '0;
		rf_wr     = '0;

		unique case (state_q)
			ST_CLEAR: begin
				// zero one word row of every lane
				mem_req.wr_en = 1'b1;
				mem_req.addr  = {clr_row_q, 2'b00};
				if (&clr_row_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				if (run_item) begin
					state_d = (item_q.mode == MODE_POP) ? ST_POP : ST_PUSH;
				end else if (out_free) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					state_d   = ST_IDLE;
					res_d.kind          = KIND_ACK;
					res_d.is_last       = 1'b1;
					res_d.stack_pointer = rf_sp;
					if (item_q.mode == MODE_WRITE) begin
						rf_wr.en   = 1'b1;
						rf_wr.idx  = item_q.reg_index;
						rf_wr.data = item_q.write_value;
						res_d.xfer_register = item_q.reg_index;
						res_d.xfer_data     = item_q.write_value;
						if (item_q.reg_index == SP_REG) begin
							res_d.stack_pointer = item_q.write_value;
						end
					end
				end
			end
			ST_PUSH: begin
				if (push_step) begin
					emit          = 1'b1;
					emit_last     = (list_rest == '0);
					mem_req.wr_en = 1'b1;
					mem_req.addr  = addr_q;
					mem_req.wdata = rf_rdata;
					res_d.kind          = KIND_STORE;
					res_d.xfer_register = cur_reg;
					res_d.mem_address   = ADDR_OUT_W'(addr_q);
					res_d.xfer_data     = rf_rdata;
					res_d.stack_pointer = sp_after_q;
					res_d.is_last       = emit_last;
					if (emit_last) begin
						rf_wr.sp_en   = 1'b1;
						rf_wr.sp_data = sp_after_q;
						state_d       = ST_IDLE;
					end
				end
			end
			ST_POP: begin
				if (pop_issue) begin
					mem_req.rd_en = 1'b1;
					mem_req.addr  = addr_q;
				end
				if (pop_emit) begin
					emit       = 1'b1;
					emit_last  = (list_q == '0);
					rf_wr.en   = 1'b1;
					rf_wr.idx  = rd_reg_q;
					rf_wr.data = mem_rdata;
					res_d.kind          = KIND_LOAD;
					res_d.xfer_register = rd_reg_q;
					res_d.mem_address   = ADDR_OUT_W'(rd_addr_q);
					res_d.xfer_data     = mem_rdata;
					res_d.stack_pointer = sp_after_q;
					res_d.is_last       = emit_last;
					if (emit_last) begin
						rf_wr.sp_en   = 1'b1;
						rf_wr.sp_data = sp_after_q;
						state_d       = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_row_q   <= '0;
			rd_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_row_q <= clr_row_q + ROW_AW'(1);
			end
			// one load is in flight or parked in the lane read registers
			if (pop_issue) begin
				rd_valid_q <= 1'b1;
			end else if (pop_emit) begin
				rd_valid_q <= 1'b0;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd;
		end
		if (state_q == ST_SETUP) begin
			list_q     <= item_q.reg_list;
			sp_after_q <= sp_new;
			// push starts at the new SP, pop at the old one
			addr_q     <= (item_q.mode == MODE_POP) ? rf_sp[MEM_AW-1:0] : sp_new[MEM_AW-1:0];
		end else if (push_step || pop_issue) begin
			list_q <= list_rest;
			addr_q <= addr_q + MEM_AW'(4);
		end
		if (pop_issue) begin
			rd_reg_q  <= cur_reg;
			rd_addr_q <= addr_q;
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// No result beat can exist before the clearing pass ends
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !res_valid_q)
		else $error("result beat during memory clear");

	// A parked load only lives inside a pop
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_q |-> (state_q == ST_POP))
		else $error("load pending outside pop");

	// The final beat of a command returns the engine to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=> (state_q == ST_IDLE))
		else $error("engine busy after final beat");

	// A beat is only loaded into the result register when it is free or draining
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!res_valid_q || res_ready))
		else $error("result beat overwritten");

endmodule

FILE: dv/tb.sv
module tb;
	import spm_pkg::*;

	// Mode 3 has no name in the package; the block acks it like an empty list
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Worst case is far below this: ~170 commands x 9 beats x the longest stall,
	// plus the memory clear after reset
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_CMDS = 140;
	localparam int SETTLE_CYCLES = 30;

	typedef struct packed {
		logic      drain;
		cmd_item_t c;
	} pending_cmd_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_item_t cmd = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	res_item_t res;

	// Predictor state: register file and byte-wide stack memory
	logic [WORD_W-1:0] gpr [NUM_REGS];
	logic [7:0]        stack_mem [MEM_BYTES];

	pending_cmd_t pending[$];
	res_item_t    expected_beats[$];

	logic cmd_took = 1'b0;
	int   send_gap = 0;
	int   stall_left = 0;
	bit   cmd_quiet = 1'b0;
	bit   res_quiet = 1'b0;
	int   mismatches = 0;
	int   cycles = 0;

	stack_push_pop_multiple_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always #6 clk = ~clk;

	// Byte address inside the stack memory: 32-bit sum, then modulo its size
	function automatic int unsigned mem_index(input logic [31:0] word_addr,
			input int unsigned off);
		logic [31:0] sum;
		sum = word_addr + off;
		return sum % MEM_BYTES;
	endfunction

	// Gap length in cycles: mostly none or short, now and then a long one
	function automatic int idle_len(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Apply one command to the predictor state and queue the beats it produces
	function automatic void predict_stack_op(input cmd_item_t c);
		logic [31:0]       sp;
		logic [31:0]       addr;
		logic [31:0]       sp_after;
		logic [WORD_W-1:0] word;
		logic [REG_AW-1:0] rn;
		int unsigned       cnt;
		bit                is_pop;
		res_item_t         r;
		cnt = $countones(c.reg_list);
		is_pop = (c.mode == MODE_POP);
		r = '0;
		r.is_last = 1'b1;
		// Register write: single ack beat carrying the written value
		if (c.mode == MODE_WRITE) begin
			gpr[c.reg_index] = c.write_value;
			r.kind = KIND_ACK;
			r.xfer_register = c.reg_index;
			r.xfer_data = c.write_value;
			r.stack_pointer = gpr[SP_REG];
			expected_beats.push_back(r);
			return;
		end
		// Empty list or unused mode: bare ack, nothing changes
		if (c.mode == MODE_UNUSED || cnt == 0) begin
			r.kind = KIND_ACK;
			r.stack_pointer = gpr[SP_REG];
			expected_beats.push_back(r);
			return;
		end
		sp = gpr[SP_REG];
		if (is_pop) begin
			addr = sp;
			sp_after = sp + 32'(4 * cnt);
		end else begin
			addr = sp - 32'(4 * cnt);
			sp_after = addr;
		end
		for (int b = 0; b < LIST_W; b++) begin
			if (!c.reg_list[b])
				continue;
			// List bit 8 means LR on push, PC on pop
			rn = (b < 8) ? REG_AW'(b) : (is_pop ? PC_REG : LR_REG);
			if (is_pop) begin
				word = '0;
				for (int j = 0; j < NUM_LANES; j++)
					word[8*j +: 8] = stack_mem[mem_index(addr, j)];
				gpr[rn] = word;
			end else begin
				word = gpr[rn];
				for (int j = 0; j < NUM_LANES; j++)
					stack_mem[mem_index(addr, j)] = word[8*j +: 8];
			end
			r.kind = is_pop ? KIND_LOAD : KIND_STORE;
			r.xfer_register = rn;
			r.mem_address = ADDR_OUT_W'(mem_index(addr, 0));
			r.xfer_data = word;
			r.stack_pointer = sp_after;
			r.is_last = 1'b0;
			expected_beats.push_back(r);
			addr += 32'd4;
		end
		gpr[SP_REG] = sp_after;
		expected_beats[$].is_last = 1'b1;
	endfunction

	task automatic queue_cmd(input logic [1:0] m, input logic [LIST_W-1:0] lst,
			input logic [REG_AW-1:0] idx, input logic [WORD_W-1:0] val,
			input logic drain);
		pending_cmd_t p;
		p.drain = drain;
		p.c.mode = m;
		p.c.reg_list = lst;
		p.c.reg_index = idx;
		p.c.write_value = val;
		pending.push_back(p);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %h, got %h", name, want, got);
		end
	endtask

	// Command driver: change inputs on the falling edge, hold a beat until taken
	always @(negedge clk) begin : drive_cmd
		pending_cmd_t nxt;
		if (arst_n && !(cmd_valid && !cmd_took)) begin
			if (send_gap > 0) begin
				send_gap--;
				cmd_valid <= 1'b0;
			end else if (pending.size() != 0 &&
					!(pending[0].drain && expected_beats.size() != 0)) begin
				nxt = pending.pop_front();
				cmd <= nxt.c;
				cmd_valid <= 1'b1;
				// Flip between bursty and gap-free stretches now and then
				if ($urandom_range(0, 14) == 0)
					cmd_quiet = !cmd_quiet;
				send_gap = idle_len(cmd_quiet);
			end else begin
				// Idle, or hold off until every expected beat has drained
				cmd_valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure, independent of res_valid
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 29) == 0)
				res_quiet = !res_quiet;
			if (stall_left > 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
				if ($urandom_range(0, 2) == 0)
					stall_left = idle_len(res_quiet);
			end
		end
	end

	// Monitor: sample both handshakes on the rising edge
	always @(posedge clk) begin : watch_beats
		res_item_t want;
		if (arst_n) begin
			cmd_took <= cmd_valid && cmd_ready;
			// Check the result beat against the oldest expectation
			if (res_valid && res_ready) begin
				if (expected_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: %p", res);
				end else begin
					want = expected_beats.pop_front();
					check_field("kind", want.kind, res.kind);
					check_field("xfer_register", want.xfer_register, res.xfer_register);
					check_field("mem_address", want.mem_address, res.mem_address);
					check_field("xfer_data", want.xfer_data, res.xfer_data);
					check_field("stack_pointer", want.stack_pointer, res.stack_pointer);
					check_field("is_last", want.is_last, res.is_last);
				end
			end
			// Predict from the command beat taken at this edge
			if (cmd_valid && cmd_ready)
				predict_stack_op(cmd);
		end
	end

	// Watchdog on total run length
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int r;
		int taken;
		logic [1:0] m;
		for (int i = 0; i < NUM_REGS; i++)
			gpr[i] = '0;
		for (int i = 0; i < MEM_BYTES; i++)
			stack_mem[i] = '0;

		// Directed: field extremes, every mode, empty lists, wrap cases
		queue_cmd(MODE_WRITE, 9'h000, SP_REG, 32'h0000_0100, 1'b0);
		queue_cmd(MODE_WRITE, 9'h1FF, 4'd0, 32'hFFFF_FFFF, 1'b0);
		queue_cmd(MODE_WRITE, 9'h000, 4'd7, 32'h0000_0000, 1'b0);
		queue_cmd(MODE_WRITE, 9'h0AA, LR_REG, 32'hA5A5_5A5A, 1'b0);
		queue_cmd(MODE_WRITE, 9'h155, PC_REG, 32'h1234_5678, 1'b0);
		queue_cmd(MODE_PUSH, 9'h1FF, 4'd15, 32'hFFFF_FFFF, 1'b0);
		queue_cmd(MODE_POP, 9'h1FF, 4'd0, 32'h0000_0000, 1'b0);
		queue_cmd(MODE_PUSH, 9'h000, 4'd9, 32'hDEAD_BEEF, 1'b0);
		queue_cmd(MODE_POP, 9'h000, 4'd3, 32'h0F0F_0F0F, 1'b0);
		queue_cmd(MODE_UNUSED, 9'h1FF, 4'd15, 32'hFFFF_FFFF, 1'b0);
		queue_cmd(MODE_PUSH, 9'h100, 4'd0, 32'h0, 1'b0);
		queue_cmd(MODE_POP, 9'h100, 4'd0, 32'h0, 1'b0);
		// Unaligned SP just above zero: push wraps below address zero
		queue_cmd(MODE_WRITE, 9'h000, SP_REG, 32'h0000_0002, 1'b1);
		queue_cmd(MODE_PUSH, 9'h0FF, 4'd0, 32'h0, 1'b0);
		queue_cmd(MODE_POP, 9'h0FF, 4'd0, 32'h0, 1'b0);
		// SP near the top of the 32-bit range: pop wraps SP past zero
		queue_cmd(MODE_WRITE, 9'h000, SP_REG, 32'hFFFF_FFF8, 1'b0);
		queue_cmd(MODE_PUSH, 9'h003, 4'd0, 32'h0, 1'b0);
		queue_cmd(MODE_POP, 9'h1FF, 4'd0, 32'h0, 1'b0);
		// SP two bytes below the end of the stack memory
		queue_cmd(MODE_WRITE, 9'h000, SP_REG, 32'h0000_0FFE, 1'b0);
		queue_cmd(MODE_PUSH, 9'h081, 4'd0, 32'h0, 1'b0);
		queue_cmd(MODE_POP, 9'h081, 4'd0, 32'h0, 1'b0);
		queue_cmd(MODE_WRITE, 9'h000, SP_REG, 32'h7FFF_F001, 1'b0);
		queue_cmd(MODE_POP, 9'h155, 4'd0, 32'h0, 1'b0);
		queue_cmd(MODE_PUSH, 9'h0AA, 4'd0, 32'h0, 1'b0);

		// Random: mostly real pushes, pops and writes; a few empty or unused
		taken = 0;
		while (taken < RANDOM_CMDS) begin
			r = $urandom_range(0, 99);
			if (r < 22)
				m = MODE_WRITE;
			else if (r < 60)
				m = MODE_PUSH;
			else if (r < 96)
				m = MODE_POP;
			else
				m = MODE_UNUSED;
			if (m == MODE_WRITE) begin
				r = $urandom_range(0, 9);
				queue_cmd(m, LIST_W'($urandom_range(0, 511)),
					REG_AW'($urandom_range(0, 15)),
					(r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom(),
					taken == 60 || taken == 130);
			end else if (m == MODE_UNUSED) begin
				queue_cmd(m, LIST_W'($urandom_range(0, 511)),
					REG_AW'($urandom_range(0, 15)), $urandom(), 1'b0);
			end else begin
				// Empty list on roughly one in ten transfers
				queue_cmd(m, ($urandom_range(0, 9) == 0) ? 9'h000 :
					LIST_W'($urandom_range(1, 511)),
					REG_AW'($urandom_range(0, 15)), $urandom(),
					taken == 60 || taken == 130);
			end
			if (m != MODE_UNUSED)
				taken++;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: everything sent, every beat back, then let the block settle
		while (pending.size() != 0 || cmd_valid || expected_beats.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
